[design/bge_pkg.sv]
// ----------------------------------------------------------------------------
// bge_pkg: shared types, constants and knot generators
// Q16.16 datapath constants, inter-stage structs, erf/tanh knot functions.
// ----------------------------------------------------------------------------
package bge_pkg;

  localparam int FRAC_BITS_DEF      = 16;
  localparam int TABLE_SEGMENTS_DEF = 256;
  localparam int VAL_W              = 32;
  localparam int SIMPSON_STEPS      = 128;

  // Q30 datapath constants (signed, one spare bit)
  localparam logic signed [31:0] K_INV_SQRT2      = 32'sd759250125;
  localparam logic signed [30:0] K_SQRT_2_OVER_PI = 31'sd856722024;
  localparam logic signed [26:0] K_CUBIC          = 27'sd48012366;
  localparam logic signed [31:0] Q30_ONE_S        = 32'sd1073741824;

  localparam logic signed [VAL_W-1:0] V_MAX = 32'sh7fff_ffff;
  localparam logic signed [VAL_W-1:0] V_MIN = 32'sh8000_0000;

  // elaboration-time constants for knot generation
  localparam logic [63:0] E_ONE           = 64'h0000_0000_4000_0000;
  localparam logic [63:0] E_HALF          = 64'h0000_0000_2000_0000;
  localparam logic [63:0] E_TWO_OVER_SQPI = 64'd1211587905;

  typedef enum logic {
    MODE_ERF  = 1'b0,
    MODE_TANH = 1'b1
  } gelu_mode_t;

  // front end -> table lookup
  typedef struct packed {
    logic signed [VAL_W-1:0] v;
    logic signed [VAL_W-1:0] z;
    gelu_mode_t              mode;
    logic                    clamp_pos;
    logic                    clamp_neg;
  } bge_arg_t;

  // table lookup -> output scale
  typedef struct packed {
    logic signed [VAL_W-1:0] v;
    logic signed [VAL_W-1:0] t;
  } bge_act_t;

  // restoring divide, used only while building knots
  function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [63:0] rem;
    q   = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem  = rem - den;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] div_term(input logic [63:0] x, input int n);
    logic [63:0] r;
    case (n)
      2:       r = x / 64'd2;
      3:       r = x / 64'd3;
      4:       r = x / 64'd4;
      5:       r = x / 64'd5;
      6:       r = x / 64'd6;
      7:       r = x / 64'd7;
      8:       r = x / 64'd8;
      9:       r = x / 64'd9;
      10:      r = x / 64'd10;
      11:      r = x / 64'd11;
      12:      r = x / 64'd12;
      13:      r = x / 64'd13;
      14:      r = x / 64'd14;
      default: r = x;
    endcase
    return r;
  endfunction

  // exp(-a), a in Q30, via Taylor of exp(-a/32) raised to the 32nd power
  function automatic logic [63:0] exp_neg_q30(input logic [63:0] a);
    logic [63:0]        r;
    logic [63:0]        term;
    logic [63:0]        s;
    logic signed [63:0] sm;
    r    = (a + 64'd16) >> 5;
    sm   = $signed(E_ONE);
    term = E_ONE;
    for (int n = 1; n <= 14; n++) begin
      term = div_term((term * r + E_HALF) >> 30, n);
      if (n[0]) sm = sm - $signed(term);
      else      sm = sm + $signed(term);
    end
    s = $unsigned(sm);
    for (int n = 0; n < 5; n++) begin
      s = (s * s + E_HALF) >> 30;
    end
    return s;
  endfunction

  function automatic logic [63:0] erf_pos_q30(input logic [63:0] ax);
    logic [63:0] sum;
    logic [63:0] t;
    logic [63:0] h;
    logic [63:0] t2;
    logic [63:0] w;
    logic [63:0] integral;
    logic [63:0] e;
    sum = '0;
    for (int i = 0; i <= SIMPSON_STEPS; i++) begin
      t  = (ax * 64'(i)) / 64'(SIMPSON_STEPS);
      h  = t >> 1;
      t2 = (h * h + (64'd1 << 27)) >> 28;
      if (i == 0 || i == SIMPSON_STEPS) w = 64'd1;
      else if (i[0])                    w = 64'd4;
      else                              w = 64'd2;
      sum = sum + w * exp_neg_q30(t2);
    end
    integral = (((sum >> 8) * ax) >> 22) / 64'(3 * SIMPSON_STEPS);
    e = (integral * E_TWO_OVER_SQPI + E_HALF) >> 30;
    return (e > E_ONE) ? E_ONE : e;
  endfunction

  function automatic logic [63:0] tanh_pos_q30(input logic [63:0] ax);
    logic [63:0] e;
    logic [63:0] den;
    logic [63:0] num;
    e   = exp_neg_q30(ax << 1);
    den = E_ONE + e;
    num = ((E_ONE - e) << 30) + (den >> 1);
    return div_u64(num, den);
  endfunction

  // knot k of a segs-segment table over [-4,4), Q30
  function automatic logic signed [31:0] knot_value(input int k, input int segs,
                                                    input logic tanh_sel);
    int          d;
    logic [63:0] mag;
    logic [63:0] ax;
    logic [63:0] val;
    d   = 2 * k - segs;
    mag = 64'((d < 0) ? -d : d);
    ax  = div_u64(mag << 32, 64'(segs));
    val = tanh_sel ? tanh_pos_q30(ax) : erf_pos_q30(ax);
    return (d < 0) ? -$signed(32'(val)) : $signed(32'(val));
  endfunction

endpackage

[design/bge_front.sv]
// ----------------------------------------------------------------------------
// bge_front: bias add and activation argument
// Six stages: saturating add, then the multiply chain for z = v/sqrt2
// (erf form) or sqrt(2/pi)(v + 0.044715 v^3) (tanh form).
// ----------------------------------------------------------------------------
module bge_front
  import bge_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [VAL_W-1:0] in_product_value,
  input  logic signed [VAL_W-1:0] in_bias_value,
  input  gelu_mode_t              mode,
  output logic                    out_valid,
  input  logic                    out_ready,
  output bge_arg_t                out_arg
);

  localparam int NSTG = 6;
  localparam int VS_W = FRAC_BITS + 4;   // |v| < 8.0 on the tanh path
  localparam int V2_W = FRAC_BITS + 7;
  localparam int P2_W = V2_W + VS_W;
  localparam int V3_W = FRAC_BITS + 11;
  localparam int P3_W = V3_W + 27;
  localparam int C_W  = P3_W - 30;
  localparam int S_W  = C_W + 1;
  localparam int P4_W = S_W + 31;

  localparam logic signed [VAL_W-1:0] BIG     = 32'sd8 <<< FRAC_BITS;
  localparam logic signed [63:0]      RND30_B = 64'sd1 <<< 29;
  localparam logic signed [63:0]      RNDF_B  = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [P2_W-1:0]  RNDF_C  = P2_W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [P3_W-1:0]  RND30_D = P3_W'(1) <<< 29;
  localparam logic signed [P4_W-1:0]  RND30_E = P4_W'(1) <<< 29;

  // ---- handshake: each stage advances when empty or when downstream moves
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] vld_nxt;
  logic [NSTG-1:0] adv;

  always_comb begin
    adv[NSTG-1] = !vld_r[NSTG-1] || out_ready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      adv[i] = !vld_r[i] || adv[i+1];
    end
  end

  assign vld_nxt  = {vld_r[NSTG-2:0], in_valid};
  assign in_ready = adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= (adv & vld_nxt) | (~adv & vld_r);
    end
  end

  // ---- stage A: saturating sum
  logic signed [VAL_W:0]   sum_a;
  logic signed [VAL_W-1:0] a_v_nxt;
  logic signed [VAL_W-1:0] a_v_r;
  gelu_mode_t              a_mode_r;

  assign sum_a = {in_product_value[VAL_W-1], in_product_value}
               + {in_bias_value[VAL_W-1], in_bias_value};

  always_comb begin
    if (sum_a[VAL_W] != sum_a[VAL_W-1]) begin
      a_v_nxt = sum_a[VAL_W] ? V_MIN : V_MAX;
    end else begin
      a_v_nxt = sum_a[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      a_v_r    <= a_v_nxt;
      a_mode_r <= mode;
    end
  end

  // ---- stage B: v*K (erf) or v*v (tanh), range flags
  logic signed [VAL_W-1:0] mul_b;
  logic signed [63:0]      b_prod_nxt;
  logic signed [63:0]      b_prod_r;
  logic signed [VAL_W-1:0] b_v_r;
  gelu_mode_t              b_mode_r;
  logic                    b_pos_r;
  logic                    b_neg_r;

  assign mul_b      = (a_mode_r == MODE_TANH) ? a_v_r : K_INV_SQRT2;
  assign b_prod_nxt = a_v_r * mul_b;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      b_prod_r <= b_prod_nxt;
      b_v_r    <= a_v_r;
      b_mode_r <= a_mode_r;
      b_pos_r  <= (a_v_r >= BIG);
      b_neg_r  <= (a_v_r <= -BIG);
    end
  end

  // ---- stage C: z for erf; v^2 * v for tanh
  logic signed [63:0]      z_full_c;
  logic signed [63:0]      v2_full_c;
  logic signed [V2_W-1:0]  v2_c;
  logic signed [VS_W-1:0]  vs_c;
  logic signed [P2_W-1:0]  c_prod_nxt;
  logic signed [P2_W-1:0]  c_prod_r;
  logic signed [VAL_W-1:0] c_z_r;
  logic signed [VAL_W-1:0] c_v_r;
  gelu_mode_t              c_mode_r;
  logic                    c_pos_r;
  logic                    c_neg_r;

  assign z_full_c   = (b_prod_r + RND30_B) >>> 30;
  assign v2_full_c  = (b_prod_r + RNDF_B) >>> FRAC_BITS;
  assign v2_c       = V2_W'(v2_full_c);
  assign vs_c       = VS_W'(b_v_r);
  assign c_prod_nxt = v2_c * vs_c;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      c_prod_r <= c_prod_nxt;
      c_z_r    <= VAL_W'(z_full_c);
      c_v_r    <= b_v_r;
      c_mode_r <= b_mode_r;
      c_pos_r  <= b_pos_r;
      c_neg_r  <= b_neg_r;
    end
  end

  // ---- stage D: v^3 * 0.044715
  logic signed [P2_W-1:0]  v3_full_d;
  logic signed [V3_W-1:0]  v3_d;
  logic signed [P3_W-1:0]  d_prod_nxt;
  logic signed [P3_W-1:0]  d_prod_r;
  logic signed [VAL_W-1:0] d_z_r;
  logic signed [VAL_W-1:0] d_v_r;
  gelu_mode_t              d_mode_r;
  logic                    d_pos_r;
  logic                    d_neg_r;

  assign v3_full_d  = (c_prod_r + RNDF_C) >>> FRAC_BITS;
  assign v3_d       = V3_W'(v3_full_d);
  assign d_prod_nxt = v3_d * K_CUBIC;

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      d_prod_r <= d_prod_nxt;
      d_z_r    <= c_z_r;
      d_v_r    <= c_v_r;
      d_mode_r <= c_mode_r;
      d_pos_r  <= c_pos_r;
      d_neg_r  <= c_neg_r;
    end
  end

  // ---- stage E: (v + c) * sqrt(2/pi)
  logic signed [P3_W-1:0]  c_full_e;
  logic signed [C_W-1:0]   cub_e;
  logic signed [VS_W-1:0]  vs_e;
  logic signed [S_W-1:0]   sum_e;
  logic signed [P4_W-1:0]  e_prod_nxt;
  logic signed [P4_W-1:0]  e_prod_r;
  logic signed [VAL_W-1:0] e_z_r;
  logic signed [VAL_W-1:0] e_v_r;
  gelu_mode_t              e_mode_r;
  logic                    e_pos_r;
  logic                    e_neg_r;

  assign c_full_e   = (d_prod_r + RND30_D) >>> 30;
  assign cub_e      = C_W'(c_full_e);
  assign vs_e       = VS_W'(d_v_r);
  assign sum_e      = S_W'(vs_e) + S_W'(cub_e);
  assign e_prod_nxt = sum_e * K_SQRT_2_OVER_PI;

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      e_prod_r <= e_prod_nxt;
      e_z_r    <= d_z_r;
      e_v_r    <= d_v_r;
      e_mode_r <= d_mode_r;
      e_pos_r  <= d_pos_r;
      e_neg_r  <= d_neg_r;
    end
  end

  // ---- stage F: pick the table argument; large |v| forces tanh to +-1
  logic signed [P4_W-1:0] in_full_f;
  bge_arg_t               f_arg_nxt;
  bge_arg_t               f_arg_r;

  assign in_full_f = (e_prod_r + RND30_E) >>> 30;

  always_comb begin
    f_arg_nxt.v         = e_v_r;
    f_arg_nxt.mode      = e_mode_r;
    f_arg_nxt.z         = (e_mode_r == MODE_TANH) ? VAL_W'(in_full_f) : e_z_r;
    f_arg_nxt.clamp_pos = (e_mode_r == MODE_TANH) && e_pos_r;
    f_arg_nxt.clamp_neg = (e_mode_r == MODE_TANH) && e_neg_r;
  end

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      f_arg_r <= f_arg_nxt;
    end
  end

  assign out_valid = vld_r[NSTG-1];
  assign out_arg   = f_arg_r;

  // ---- checks
  a_rst_clear: assert property (@(posedge clk) !rst_n |=> vld_r == '0)
    else $error("front: valid bits not cleared by reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (($past(vld_r) & ~$past(adv) & ~vld_r) == '0))
    else $error("front: stalled stage lost its request");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_arg)))
    else $error("front: stalled request changed");

endmodule

[design/bge_lookup.sv]
// ----------------------------------------------------------------------------
// bge_lookup: interpolated erf/tanh table read
// Four stages: segment address, knot read, slope multiply, sum and clamp.
// ----------------------------------------------------------------------------
module bge_lookup
  import bge_pkg::*;
#(
  parameter int FRAC_BITS      = FRAC_BITS_DEF,
  parameter int TABLE_SEGMENTS = TABLE_SEGMENTS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  bge_arg_t in_arg,
  output logic     out_valid,
  input  logic     out_ready,
  output bge_act_t out_act
);

  localparam int NSTG  = 4;
  localparam int ZO_W  = FRAC_BITS + 3;
  localparam int IDX_W = $clog2(TABLE_SEGMENTS + 1);
  localparam int U_W   = ZO_W + IDX_W;
  localparam int PR_W  = 33 + ZO_W + 1;

  localparam logic signed [VAL_W-1:0] LIM    = 32'sd4 <<< FRAC_BITS;
  localparam logic signed [PR_W-1:0]  RND_PR = PR_W'(1) <<< (ZO_W - 1);

  // ---- knot tables, built at elaboration
  logic signed [VAL_W-1:0] erf_tab  [TABLE_SEGMENTS+1];
  logic signed [VAL_W-1:0] tanh_tab [TABLE_SEGMENTS+1];

  for (genvar k = 0; k <= TABLE_SEGMENTS; k++) begin : g_knot
    localparam logic signed [VAL_W-1:0] ERF_K  = knot_value(k, TABLE_SEGMENTS, 1'b0);
    localparam logic signed [VAL_W-1:0] TANH_K = knot_value(k, TABLE_SEGMENTS, 1'b1);
    assign erf_tab[k]  = ERF_K;
    assign tanh_tab[k] = TANH_K;
  end

  // ---- handshake
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] vld_nxt;
  logic [NSTG-1:0] adv;

  always_comb begin
    adv[NSTG-1] = !vld_r[NSTG-1] || out_ready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      adv[i] = !vld_r[i] || adv[i+1];
    end
  end

  assign vld_nxt  = {vld_r[NSTG-2:0], in_valid};
  assign in_ready = adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= (adv & vld_nxt) | (~adv & vld_r);
    end
  end

  // ---- stage G: segment index and fraction
  logic                    below_g;
  logic                    above_g;
  logic [ZO_W-1:0]         zoff_g;
  logic [U_W-1:0]          u_g;
  logic [IDX_W-1:0]        k_g;
  logic [IDX_W-1:0]        g_idx_nxt;
  logic [IDX_W-1:0]        g_idx_r;
  logic [ZO_W-1:0]         g_frac_r;
  logic signed [VAL_W-1:0] g_v_r;
  gelu_mode_t              g_mode_r;
  logic                    g_pos_r;
  logic                    g_neg_r;

  assign below_g = (in_arg.z < -LIM);
  assign above_g = (in_arg.z >= LIM);
  assign zoff_g  = ZO_W'(in_arg.z + LIM);
  assign u_g     = U_W'(zoff_g) * U_W'(TABLE_SEGMENTS);
  assign k_g     = u_g[U_W-1:ZO_W];

  always_comb begin
    if (k_g >= IDX_W'(TABLE_SEGMENTS)) begin
      g_idx_nxt = IDX_W'(TABLE_SEGMENTS - 1);
    end else begin
      g_idx_nxt = k_g;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      g_idx_r  <= g_idx_nxt;
      g_frac_r <= u_g[ZO_W-1:0];
      g_v_r    <= in_arg.v;
      g_mode_r <= in_arg.mode;
      // forced tanh wins over the table range test
      g_pos_r  <= in_arg.clamp_pos || (!in_arg.clamp_neg && above_g);
      g_neg_r  <= in_arg.clamp_neg || (!in_arg.clamp_pos && below_g);
    end
  end

  // ---- stage H: read both knots of the segment
  logic [IDX_W-1:0]        idx1_h;
  logic signed [VAL_W-1:0] lo_h;
  logic signed [VAL_W-1:0] hi_h;
  logic signed [VAL_W-1:0] h_lo_r;
  logic signed [VAL_W:0]   h_diff_r;
  logic [ZO_W-1:0]         h_frac_r;
  logic signed [VAL_W-1:0] h_v_r;
  logic                    h_pos_r;
  logic                    h_neg_r;

  assign idx1_h = g_idx_r + IDX_W'(1);
  assign lo_h   = (g_mode_r == MODE_TANH) ? tanh_tab[g_idx_r] : erf_tab[g_idx_r];
  assign hi_h   = (g_mode_r == MODE_TANH) ? tanh_tab[idx1_h]  : erf_tab[idx1_h];

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      h_lo_r   <= lo_h;
      h_diff_r <= (VAL_W+1)'(hi_h) - (VAL_W+1)'(lo_h);
      h_frac_r <= g_frac_r;
      h_v_r    <= g_v_r;
      h_pos_r  <= g_pos_r;
      h_neg_r  <= g_neg_r;
    end
  end

  // ---- stage I: slope * fraction
  logic signed [ZO_W:0]    frac_i;
  logic signed [PR_W-1:0]  i_prod_nxt;
  logic signed [PR_W-1:0]  i_prod_r;
  logic signed [VAL_W-1:0] i_lo_r;
  logic signed [VAL_W-1:0] i_v_r;
  logic                    i_pos_r;
  logic                    i_neg_r;

  assign frac_i     = {1'b0, h_frac_r};
  assign i_prod_nxt = h_diff_r * frac_i;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      i_prod_r <= i_prod_nxt;
      i_lo_r   <= h_lo_r;
      i_v_r    <= h_v_r;
      i_pos_r  <= h_pos_r;
      i_neg_r  <= h_neg_r;
    end
  end

  // ---- stage J: interpolated value, saturated ends
  logic signed [PR_W-1:0]  step_j;
  logic signed [VAL_W-1:0] j_t_nxt;
  logic signed [VAL_W-1:0] j_t_r;
  logic signed [VAL_W-1:0] j_v_r;

  assign step_j = (i_prod_r + RND_PR) >>> ZO_W;

  always_comb begin
    if (i_pos_r) begin
      j_t_nxt = Q30_ONE_S;
    end else if (i_neg_r) begin
      j_t_nxt = -Q30_ONE_S;
    end else begin
      j_t_nxt = i_lo_r + VAL_W'(step_j);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      j_t_r <= j_t_nxt;
      j_v_r <= i_v_r;
    end
  end

  assign out_valid = vld_r[NSTG-1];
  assign out_act   = '{v: j_v_r, t: j_t_r};

  // ---- checks
  a_t_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[NSTG-1] |-> (j_t_r <= Q30_ONE_S && j_t_r >= -Q30_ONE_S))
    else $error("lookup: activation factor outside [-1,1]");

  a_clamp_excl: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid |-> !(in_arg.clamp_pos && in_arg.clamp_neg))
    else $error("lookup: both clamp flags set");

  a_clamp_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_arg.mode == MODE_ERF) |-> !(in_arg.clamp_pos || in_arg.clamp_neg))
    else $error("lookup: tanh clamp on an erf request");

endmodule

[design/bge_scale.sv]
// ----------------------------------------------------------------------------
// bge_scale: final GELU scaling
// Two stages: v * (1 + t), then round by 2^31 and saturate to 32 bits.
// ----------------------------------------------------------------------------
module bge_scale
  import bge_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  bge_act_t                in_act,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [VAL_W-1:0] out_activated_value
);

  localparam int NSTG = 2;
  localparam int P_W  = 2 * VAL_W + 1;

  localparam logic signed [VAL_W:0] ONE_Q30 = 33'sd1073741824;
  localparam logic signed [P_W-1:0] RND31   = P_W'(1) <<< 30;
  localparam logic signed [P_W-1:0] Y_MAX   = P_W'(V_MAX);
  localparam logic signed [P_W-1:0] Y_MIN   = P_W'(V_MIN);

  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] vld_nxt;
  logic [NSTG-1:0] adv;

  assign adv[1]   = !vld_r[1] || out_ready;
  assign adv[0]   = !vld_r[0] || adv[1];
  assign vld_nxt  = {vld_r[0], in_valid};
  assign in_ready = adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= (adv & vld_nxt) | (~adv & vld_r);
    end
  end

  // ---- stage K: v * (1 + t); 1 + t lies in [0, 2]
  logic signed [VAL_W:0]   onept_k;
  logic signed [P_W-1:0]   k_prod_nxt;
  logic signed [P_W-1:0]   k_prod_r;
  logic signed [VAL_W-1:0] k_v_r;

  assign onept_k    = ONE_Q30 + (VAL_W+1)'(in_act.t);
  assign k_prod_nxt = in_act.v * onept_k;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      k_prod_r <= k_prod_nxt;
      k_v_r    <= in_act.v;
    end
  end

  // ---- stage L: half, round, saturate
  logic signed [P_W-1:0]   r_l;
  logic signed [VAL_W-1:0] l_y_nxt;
  logic signed [VAL_W-1:0] l_y_r;
  logic signed [VAL_W-1:0] l_v_r;

  assign r_l = (k_prod_r + RND31) >>> 31;

  always_comb begin
    if (r_l > Y_MAX) begin
      l_y_nxt = V_MAX;
    end else if (r_l < Y_MIN) begin
      l_y_nxt = V_MIN;
    end else begin
      l_y_nxt = VAL_W'(r_l);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      l_y_r <= l_y_nxt;
      l_v_r <= k_v_r;
    end
  end

  assign out_valid           = vld_r[1];
  assign out_activated_value = l_y_r;

  // ---- checks: GELU keeps the sign of v and never grows its magnitude
  a_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[1] && !l_v_r[VAL_W-1]) |-> (!l_y_r[VAL_W-1] && l_y_r <= l_v_r))
    else $error("scale: result out of [0, v] for v >= 0");

  a_neg: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[1] && l_v_r[VAL_W-1]) |-> (l_y_r >= l_v_r && l_y_r <= 0))
    else $error("scale: result out of [v, 0] for v < 0");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_activated_value)))
    else $error("scale: stalled result changed");

endmodule

[design/bias_gelu_epilogue.sv]
// ----------------------------------------------------------------------------
// bias_gelu_epilogue: bias add + GELU activation, signed Q16.16
// Takes one matrix-product element and its column bias per request, returns
// GELU(product + bias) with the sum and the result saturated to 32 bits.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel in_valid/in_ready carries in_product_value and
//    in_bias_value; output channel out_valid/out_ready carries
//    out_activated_value. Requests leave in the order they arrive.
//  - cfg_we/cfg_wdata write the mode bit: 0 = erf form, 1 = tanh form.
//    Write it only while the pipeline is empty; each request picks up the
//    mode as it enters.
//  - 12 register stages (6 front-end, 4 table, 2 scale), each holding one
//    request. Throughput is one request per cycle while out_ready stays
//    high; each stage moves its request on when the next one can take it.
//  - Reset (rst_n low at a clock edge) empties every stage and sets the
//    mode to erf. The knot tables are constants, so no warm-up pass.
//  - Each stage holds its request while the next one is full and blocked.
//    A stalled receiver backs the pipeline up stage by stage; in_ready
//    stays high while any empty stage remains to absorb requests.
// ----------------------------------------------------------------------------
module bias_gelu_epilogue
  import bge_pkg::*;
#(
  parameter int FRAC_BITS      = FRAC_BITS_DEF,
  parameter int TABLE_SEGMENTS = TABLE_SEGMENTS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // request channel
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [VAL_W-1:0] in_product_value,
  input  logic signed [VAL_W-1:0] in_bias_value,
  // result channel
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [VAL_W-1:0] out_activated_value,
  // mode register
  input  logic                    cfg_we,
  input  logic [0:0]              cfg_wdata
);

  // mode register; only the low bit exists
  gelu_mode_t gelu_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gelu_mode_r <= MODE_ERF;
    end else if (cfg_we) begin
      gelu_mode_r <= gelu_mode_t'(cfg_wdata[0]);
    end
  end

  // front end -> lookup
  logic     arg_valid;
  logic     arg_ready;
  bge_arg_t arg;

  // lookup -> scale
  logic     act_valid;
  logic     act_ready;
  bge_act_t act;

  // sum, saturate and form the erf/tanh argument
  bge_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_product_value (in_product_value),
    .in_bias_value    (in_bias_value),
    .mode             (gelu_mode_r),
    .out_valid        (arg_valid),
    .out_ready        (arg_ready),
    .out_arg          (arg)
  );

  // interpolate erf or tanh from the knot tables; +-1 outside [-4,4)
  bge_lookup #(
    .FRAC_BITS      (FRAC_BITS),
    .TABLE_SEGMENTS (TABLE_SEGMENTS)
  ) u_lookup (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (arg_valid),
    .in_ready  (arg_ready),
    .in_arg    (arg),
    .out_valid (act_valid),
    .out_ready (act_ready),
    .out_act   (act)
  );

  // y = 0.5 * v * (1 + t), rounded and saturated; last stage is the
  // output register
  bge_scale u_scale (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (act_valid),
    .in_ready            (act_ready),
    .in_act              (act),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_activated_value (out_activated_value)
  );

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for bias_gelu_epilogue
// Sends product/bias requests under random valid gaps and result back
// pressure, in both GELU modes, and compares every result with an in-bench
// Q16.16 GELU predictor built on its own erf/tanh knot tables.
// ----------------------------------------------------------------------------
module tb_top;
  import bge_pkg::*;

  // Q30 scale used by the knot tables and the activation math
  localparam longint    ONE_Q30  = 64'sd1073741824;
  localparam bit [63:0] U_ONE    = 64'd1 << 30;
  localparam bit [63:0] U_HALF   = 64'd1 << 29;
  localparam longint    INV_SQRT2    = 64'sd759250125;
  localparam longint    SQRT_2_BY_PI = 64'sd856722024;
  localparam longint    CUBIC_COEF   = 64'sd48012366;
  localparam bit [63:0] TWO_BY_SQRTPI = 64'd1211587905;
  localparam int        SEGS     = TABLE_SEGMENTS_DEF;
  localparam int        FRAC     = FRAC_BITS_DEF;
  localparam int        SIMPSON  = 128;
  // no accept on either channel for this long means the block is hung
  localparam int        STALL_LIMIT = 2000;
  // pipeline depth plus margin, for the tail wait
  localparam int        TAIL_CYCLES = 20;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic signed [VAL_W-1:0] in_product_value = '0;
  logic signed [VAL_W-1:0] in_bias_value = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [VAL_W-1:0] out_activated_value;
  logic                    cfg_we = 1'b0;
  logic [0:0]              cfg_wdata = '0;

  // predictor state: knot tables and a copy of the mode register
  int         erf_knots  [0:SEGS];
  int         tanh_knots [0:SEGS];
  gelu_mode_t mode_now = MODE_ERF;

  logic signed [VAL_W-1:0] pending_activations [$];
  int  error_count  = 0;
  int  stall_cycles = 0;
  bit  steady       = 1'b0;   // disables idling on both sides

  always #1 clk = ~clk;

  bias_gelu_epilogue dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_product_value    (in_product_value),
    .in_bias_value       (in_bias_value),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_activated_value (out_activated_value),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // Fixed-point helpers
  // --------------------------------------------------------------------------

  // shift right with round half up (floor after adding half an LSB)
  function automatic longint round_shr(longint x, int s);
    return (x + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // exp(-a) in Q30: 14-term Taylor of exp(-a/32), then squared five times
  function automatic bit [63:0] exp_neg(bit [63:0] a);
    bit [63:0] r;
    bit [63:0] term;
    bit [63:0] s;
    longint    acc;
    r    = (a + 64'd16) >> 5;
    term = U_ONE;
    acc  = ONE_Q30;
    for (int n = 1; n <= 14; n++) begin
      term = ((term * r + U_HALF) >> 30) / 64'(n);
      if (n % 2 == 1) acc = acc - longint'(term);
      else            acc = acc + longint'(term);
    end
    s = acc;
    repeat (5) s = (s * s + U_HALF) >> 30;
    return s;
  endfunction

  // erf(ax), ax >= 0 in Q30: Simpson sum of exp(-t^2), clamped to one
  function automatic bit [63:0] erf_mag(bit [63:0] ax);
    bit [63:0] acc;
    bit [63:0] t;
    bit [63:0] h;
    bit [63:0] t_sq;
    bit [63:0] w;
    bit [63:0] area;
    bit [63:0] e;
    acc = '0;
    for (int i = 0; i <= SIMPSON; i++) begin
      t    = (ax * 64'(i)) / 64'(SIMPSON);
      h    = t >> 1;
      t_sq = (h * h + (64'd1 << 27)) >> 28;
      if (i == 0 || i == SIMPSON) w = 64'd1;
      else if (i % 2 == 1)        w = 64'd4;
      else                        w = 64'd2;
      acc = acc + w * exp_neg(t_sq);
    end
    area = (((acc >> 8) * ax) >> 22) / 64'(3 * SIMPSON);
    e    = (area * TWO_BY_SQRTPI + U_HALF) >> 30;
    return (e > U_ONE) ? U_ONE : e;
  endfunction

  function automatic bit [63:0] tanh_mag(bit [63:0] ax);
    bit [63:0] e;
    bit [63:0] den;
    e   = exp_neg(ax << 1);
    den = U_ONE + e;
    return (((U_ONE - e) << 30) + den / 64'd2) / den;
  endfunction

  // odd-symmetric knots at x = 4*(2k-S)/S
  task automatic build_knots();
    int        d;
    bit [63:0] ax;
    for (int k = 0; k <= SEGS; k++) begin
      d  = 2 * k - SEGS;
      ax = (64'((d < 0) ? -d : d) << 32) / 64'(SEGS);
      erf_knots[k]  = (d < 0) ? -int'(erf_mag(ax))  : int'(erf_mag(ax));
      tanh_knots[k] = (d < 0) ? -int'(tanh_mag(ax)) : int'(tanh_mag(ax));
    end
  endtask

  // interpolated knot read; z in Q16.16, result in Q30, saturating outside [-4,4)
  function automatic longint knot_lerp(bit use_tanh, longint z);
    longint lim;
    longint u;
    longint frac;
    longint lo;
    longint diff;
    int     k;
    lim = 64'sd4 <<< FRAC;
    if (z < -lim)  return -ONE_Q30;
    if (z >= lim)  return ONE_Q30;
    u    = (z + lim) * SEGS;
    k    = int'(u >>> (FRAC + 3));
    frac = u & ((64'sd1 <<< (FRAC + 3)) - 1);
    if (k >= SEGS) k = SEGS - 1;
    lo   = use_tanh ? tanh_knots[k] : erf_knots[k];
    diff = longint'(use_tanh ? tanh_knots[k + 1] : erf_knots[k + 1]) - lo;
    return lo + round_shr(diff * frac, FRAC + 3);
  endfunction

  // GELU(product + bias) in the given mode
  function automatic logic signed [VAL_W-1:0] gelu_of_sum(
      logic signed [VAL_W-1:0] prod_val, logic signed [VAL_W-1:0] bias_val,
      gelu_mode_t mode);
    longint v;
    longint t;
    longint v2;
    longint v3;
    longint cub;
    longint arg;
    longint big;
    big = 64'sd8 <<< FRAC;
    v   = clamp32(longint'(prod_val) + longint'(bias_val));
    if (mode == MODE_ERF) begin
      t = knot_lerp(1'b0, round_shr(v * INV_SQRT2, 30));
    end else if (v >= big) begin
      t = ONE_Q30;           // tanh argument past the table: sign(v)
    end else if (v <= -big) begin
      t = -ONE_Q30;
    end else begin
      v2  = round_shr(v * v, FRAC);
      v3  = round_shr(v2 * v, FRAC);
      cub = round_shr(v3 * CUBIC_COEF, 30);
      arg = round_shr((v + cub) * SQRT_2_BY_PI, 30);
      t   = knot_lerp(1'b1, arg);
    end
    return VAL_W'(clamp32(round_shr(v * (ONE_Q30 + t), 31)));
  endfunction

  // --------------------------------------------------------------------------
  // Driver, checker and watchdog
  // --------------------------------------------------------------------------

  task automatic report_error(string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  // one request; random gap in front, held until accepted
  task automatic send_request(logic signed [VAL_W-1:0] prod_val,
                              logic signed [VAL_W-1:0] bias_val);
    while (!steady && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_product_value <= prod_val;
    in_bias_value    <= bias_val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_activations.push_back(gelu_of_sum(prod_val, bias_val, mode_now));
  endtask

  // stop sending and wait for every outstanding result
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_activations.size() != 0) @(posedge clk);
  endtask

  // mode write: only with the pipeline empty
  task automatic set_gelu_mode(gelu_mode_t mode);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we   <= 1'b0;
    mode_now  = mode;
  endtask

  // result checker plus receiver back pressure
  always @(posedge clk) begin
    logic signed [VAL_W-1:0] want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_activations.size() == 0) begin
        report_error($sformatf("unexpected result %0d", out_activated_value));
      end else begin
        want = pending_activations.pop_front();
        if (out_activated_value !== want)
          report_error($sformatf("activated_value got %0d want %0d",
                                 out_activated_value, want));
      end
    end
    out_ready <= steady || ($urandom_range(99) >= 33);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else                                                    stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // erf form, mode as left by reset
  task automatic test_erf_directed();
    send_request(32'sd0, 32'sd0);
    send_request(V_MAX, 32'sd0);
    send_request(V_MIN, 32'sd0);
    send_request(32'sd0, V_MAX);
    send_request(32'sd0, V_MIN);
    send_request(V_MAX, V_MAX);          // sum overflow, high side
    send_request(V_MIN, V_MIN);          // sum overflow, low side
    send_request(32'sd65536, 32'sd0);    // +1.0
    send_request(-32'sd65536, 32'sd0);   // -1.0
    // erf argument right at -4: first knot, and one LSB past it
    send_request(-32'sd370727, 32'sd0);
    send_request(-32'sd370000, -32'sd728);
    send_request(-32'sd370729, 32'sd0);
    // erf argument just under and right at +4
    send_request(32'sd370726, 32'sd0);
    send_request(32'sd370000, 32'sd727);
  endtask

  task automatic test_tanh_directed();
    set_gelu_mode(MODE_TANH);
    send_request(32'sd0, 32'sd0);
    send_request(32'sd262144, 32'sd262144);   // exactly +8: sign shortcut
    send_request(32'sd524287, 32'sd0);        // just below +8: cubic path
    send_request(-32'sd524288, 32'sd0);       // exactly -8
    send_request(-32'sd524287, 32'sd0);
    send_request(32'sd65536, 32'sd0);
    send_request(-32'sd65536, -32'sd1);
    send_request(V_MAX, V_MAX);
    send_request(V_MIN, V_MIN);
    send_request(32'sd1, -32'sd1);
  endtask

  // signed random value in [-2^bits, 2^bits)
  function automatic logic signed [VAL_W-1:0] rand_span(int bits);
    return $signed($urandom) >>> (31 - bits);
  endfunction

  task automatic test_random(gelu_mode_t mode, int count, bit no_idle);
    logic signed [VAL_W-1:0] p;
    logic signed [VAL_W-1:0] b;
    int                      pick;
    set_gelu_mode(mode);
    steady = no_idle;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        // |sum| under about 10, which covers the interpolated part of both tables
        p = rand_span(19);
        b = rand_span(17);
      end else if (pick < 65) begin
        p = rand_span($urandom_range(20, 30));
        b = rand_span($urandom_range(10, 24));
      end else if (pick < 85) begin
        p = $urandom;
        b = $urandom;
      end else begin
        // near the ends of the range, bias pushing toward overflow
        if ($urandom_range(1)) begin
          p = V_MAX - rand_span(12) - 32'sd4096;
          b = rand_span(20) & 32'sh7fff_ffff;
        end else begin
          p = V_MIN + rand_span(12) + 32'sd4096;
          b = rand_span(20) | 32'sh8000_0000;
        end
      end
      send_request(p, b);
    end
    steady = 1'b0;
  endtask

  initial begin
    build_knots();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_erf_directed();
    test_tanh_directed();
    test_random(MODE_ERF, 250, 1'b0);
    test_random(MODE_TANH, 250, 1'b1);   // back-to-back, no stalls
    test_random(MODE_ERF, 125, 1'b0);
    test_random(MODE_TANH, 125, 1'b0);

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[bias_gelu_epilogue.f]
design/bge_pkg.sv
design/bge_front.sv
design/bge_lookup.sv
design/bge_scale.sv
design/bias_gelu_epilogue.sv
tb/sv/tb_top.sv
